>>> src/ypcb_pkg.sv
// Shared types, constants and the arctangent table for the yaw/pitch camera basis block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ypcb_pkg;

  // Iterative sine/cosine unit
  localparam int TRIG_STEPS_DEF = 16;
  localparam int TBL_IDX_W      = 5;   // the arctangent table has 23 entries
  localparam int ANG_W          = 26;  // trig angle in degrees, signed Q.16
  localparam int Z_W            = 25;  // residual angle inside the rotation loop
  localparam int XY_W           = 32;  // Q2.30 vector components
  localparam int PROD_W         = 64;

  localparam logic signed [XY_W-1:0]  GAIN_Q30 = 32'sd652032874;
  localparam logic signed [ANG_W-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360_Q16 = 26'sd23592960;

  // Angle state
  localparam int YAW_W   = 21;
  localparam int PITCH_W = 20;
  localparam int FOV_W   = 15;
  localparam int TS_W    = 16;
  localparam int WRAP_W  = 28;  // yaw before reduction, made non-negative

  localparam logic [YAW_W-1:0]          YAW_RST    = 21'd1105920;
  localparam logic [WRAP_W-1:0]         YAW_MOD    = 28'd1474560;
  localparam logic signed [29:0]        YAW_MOD_X128 = 30'sd188743680;
  localparam logic signed [PITCH_W-1:0] PITCH_LIM  = 20'sd364544;
  localparam logic [FOV_W-1:0]          FOV_RST    = 15'd11520;
  localparam logic [FOV_W-1:0]          FOV_MIN    = 15'd256;
  localparam logic [FOV_W-1:0]          FOV_MAX    = 15'd23040;
  localparam logic [TS_W-1:0]           TS_RST     = 16'd410;

  localparam logic [15:0] UNIT_Q14 = 16'd16384;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_PITCH,
    S_WRAP,
    S_YAW_GO,
    S_YAW_RUN,
    S_PITCH_GO,
    S_PITCH_RUN,
    S_PROD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } trig_stat_t;

  // Arctangent of 2^-i in degrees, Q.16.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/ypcb_mul.sv
// Shared signed 32 x 32 multiplier with a registered product.
// Depends on ypcb_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module ypcb_mul
  import ypcb_pkg::*;
(
  input  wire                      clk,
  input  wire logic signed [XY_W-1:0]   a,
  input  wire logic signed [XY_W-1:0]   b,
  output logic signed [PROD_W-1:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

>>> src/ypcb_cordic.sv
// Rotation-mode CORDIC giving sine and cosine in Q2.30, one iteration per cycle.
// Depends on ypcb_pkg for widths, the gain constant and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module ypcb_cordic
  import ypcb_pkg::*;
#(
  parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire logic signed [ANG_W-1:0] angle,
  output trig_stat_t                 stat,
  output logic signed [XY_W-1:0]     sin_q30,
  output logic signed [XY_W-1:0]     cos_q30
);

  localparam int CNT_W = $clog2(TRIG_STEPS);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        iter_r;
  logic signed [XY_W-1:0]  x_r;
  logic signed [XY_W-1:0]  y_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    neg_r;

  logic signed [ANG_W-1:0] a_half;
  logic signed [ANG_W-1:0] a_quad;
  logic                    a_neg;
  logic signed [XY_W-1:0]  x_sh;
  logic signed [XY_W-1:0]  y_sh;
  logic signed [Z_W-1:0]   atan_i;

  // Fold the start angle into -90..90 degrees; outside that the result is negated.
  always_comb begin
    a_half = (angle >= DEG180_Q16) ? angle - DEG360_Q16 : angle;
    a_quad = a_half;
    a_neg  = 1'b0;
    if (a_half > DEG90_Q16) begin
      a_quad = a_half - DEG180_Q16;
      a_neg  = 1'b1;
    end else if (a_half < -DEG90_Q16) begin
      a_quad = a_half + DEG180_Q16;
      a_neg  = 1'b1;
    end
  end

  assign x_sh   = x_r >>> iter_r;
  assign y_sh   = y_r >>> iter_r;
  assign atan_i = atan_q16(TBL_IDX_W'(iter_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        if (iter_r == CNT_W'(TRIG_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          iter_r <= iter_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= GAIN_Q30;
      y_r   <= '0;
      z_r   <= Z_W'(a_quad);
      neg_r <= a_neg;
    end else if (busy_r) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_i;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_i;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign sin_q30   = neg_r ? -y_r : y_r;
  assign cos_q30   = neg_r ? -x_r : x_r;

endmodule

`default_nettype wire

>>> src/yaw_pitch_camera_basis.sv
// Yaw/pitch camera basis: angle accumulation and unit front, right and up vectors.
// An item passes S_MUL_X, S_MUL_Y, S_PITCH, S_WRAP, S_YAW_GO, S_YAW_RUN, S_PITCH_GO,
// S_PITCH_RUN, S_PROD and S_OUT, using the single CORDIC unit twice and the shared
// multiplier. in_tready is high only while the sequencer idles; one item is in flight.
// Reset (rst_n, synchronous, active low): yaw 270 degrees, pitch 0, view angle 45 degrees,
// turn speed 410, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module yaw_pitch_camera_basis
  import ypcb_pkg::*;
#(
  parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  // Configuration: turn_speed, unsigned Q4.12 degrees per pointer count
  input  wire          cfg_wen,
  input  wire  [15:0]  cfg_wdata,
  // Input stream
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [31:0]  in_tdata,   // delta_x[11:0], delta_y[23:12], scroll_step[31:24]
  // Result stream
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [183:0] out_tdata   // front_x[15:0], front_y[31:16], front_z[47:32],
                                   // right_x[63:48], right_z[79:64], up_x[95:80],
                                   // up_y[111:96], up_z[127:112], yaw_now[148:128],
                                   // pitch_now[168:149], view_angle[183:169]
);

  // Rounding of a Q2.30 x Q2.30 product to Q1.14, half away from zero, then saturated.
  // The optional negation is folded into the sign so that rounding stays symmetric.
  function automatic logic signed [15:0] rnd_prod(input logic signed [PROD_W-1:0] v,
                                                  input logic neg);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    logic [15:0]       m16;
    logic              sgn;
    sgn = v[PROD_W-1] ^ neg;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + (PROD_W'(1) << 45)) >> 46;
    m16 = (q > PROD_W'(UNIT_Q14)) ? UNIT_Q14 : q[15:0];
    return sgn ? $signed(-m16) : $signed(m16);
  endfunction

  // Rounding of a single Q2.30 value to Q1.14 with the same rules.
  function automatic logic signed [15:0] rnd_unit(input logic signed [XY_W-1:0] v,
                                                  input logic neg);
    logic [XY_W-1:0] mag;
    logic [XY_W-1:0] q;
    logic [15:0]     m16;
    logic            sgn;
    sgn = v[XY_W-1] ^ neg;
    mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
    q   = (mag + (XY_W'(1) << 15)) >> 16;
    m16 = (q > XY_W'(UNIT_Q14)) ? UNIT_Q14 : q[15:0];
    return sgn ? $signed(-m16) : $signed(m16);
  endfunction

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  // Architectural state and configuration
  logic [TS_W-1:0]          ts_r;
  logic [YAW_W-1:0]         yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic [FOV_W-1:0]         fov_r;

  // Per-item working registers
  logic [11:0]              dx_r;
  logic [11:0]              dy_r;
  logic [WRAP_W-1:0]        wrap_r;
  logic signed [XY_W-1:0]   sy_r, cy_r, sp_r, cp_r;
  logic signed [15:0]       front_x_r, front_z_r, up_x_r, up_z_r;

  logic                     out_tvalid_r;
  logic [183:0]             out_tdata_r;

  // Shared units
  logic signed [XY_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     trig_start;
  logic signed [ANG_W-1:0]  trig_angle;
  trig_stat_t               trig_stat;
  logic signed [XY_W-1:0]   trig_sin, trig_cos;

  // Datapath helpers
  logic                     in_xfer;
  logic                     out_load;
  logic signed [16:0]       fov_sum;
  logic signed [29:0]       yaw_sum;
  logic signed [29:0]       yaw_pos;
  logic signed [29:0]       pitch_sum;
  logic [WRAP_W-1:0]        wrap_step;
  logic signed [15:0]       prod_rnd;

  ypcb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ypcb_cordic #(
    .TRIG_STEPS (TRIG_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (trig_start),
    .angle   (trig_angle),
    .stat    (trig_stat),
    .sin_q30 (trig_sin),
    .cos_q30 (trig_cos)
  );

  assign in_xfer = in_tvalid && in_tready;

  // The view angle moves by whole degrees (Q7.8), so the scroll step is shifted by eight.
  assign fov_sum = $signed({2'b00, fov_r}) - $signed({in_tdata[31], in_tdata[31:24], 8'd0});

  // Yaw: the sum is lifted by 128 turns when negative so that the reduction below only
  // ever subtracts; seven conditional subtractions of 64..1 turns finish the modulo.
  assign yaw_sum   = $signed({9'd0, yaw_r}) + $signed(mul_p[29:0]);
  assign yaw_pos   = yaw_sum[29] ? yaw_sum + YAW_MOD_X128 : yaw_sum;
  assign wrap_step = YAW_MOD << step_r;

  assign pitch_sum = $signed({{10{pitch_r[PITCH_W-1]}}, pitch_r}) + $signed(mul_p[29:0]);

  // Products for up_x and up_z are negated; the first two are not.
  assign prod_rnd = rnd_prod(mul_p, step_r >= 3'd3);

  // Sequencer: next state, handshake and the operands of the shared units.
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    in_tready  = 1'b0;
    out_load   = 1'b0;
    trig_start = 1'b0;
    trig_angle = $signed({1'b0, wrap_r[YAW_W-1:0], 4'd0});
    mul_a      = $signed({{20{dx_r[11]}}, dx_r});
    mul_b      = $signed({16'd0, ts_r});

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X: begin
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        mul_a     = $signed({{20{dy_r[11]}}, dy_r});
        state_nxt = S_PITCH;
      end
      S_PITCH: begin
        step_nxt  = 3'd6;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          state_nxt = S_YAW_GO;
        end
      end
      S_YAW_GO: begin
        trig_start = 1'b1;
        state_nxt  = S_YAW_RUN;
      end
      S_YAW_RUN: begin
        if (trig_stat.done) begin
          state_nxt = S_PITCH_GO;
        end
      end
      S_PITCH_GO: begin
        trig_start = 1'b1;
        trig_angle = $signed({{2{pitch_r[PITCH_W-1]}}, pitch_r, 4'd0});
        state_nxt  = S_PITCH_RUN;
      end
      S_PITCH_RUN: begin
        if (trig_stat.done) begin
          step_nxt  = 3'd0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        // Operand pair k goes in at step k; its product is taken at step k+1.
        case (step_r)
          3'd0: begin
            mul_a = cp_r;
            mul_b = cy_r;
          end
          3'd1: begin
            mul_a = cp_r;
            mul_b = sy_r;
          end
          3'd2: begin
            mul_a = cy_r;
            mul_b = sp_r;
          end
          3'd3: begin
            mul_a = sy_r;
            mul_b = sp_r;
          end
          default: begin
            mul_a = cp_r;
            mul_b = cy_r;
          end
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // The previous result may still sit in the output register.
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Configuration register and angle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= TS_RST;
      yaw_r   <= YAW_RST;
      pitch_r <= '0;
      fov_r   <= FOV_RST;
    end else begin
      if (cfg_wen) begin
        ts_r <= cfg_wdata;
      end
      if (in_xfer) begin
        if (fov_sum > $signed({2'b00, FOV_MAX})) begin
          fov_r <= FOV_MAX;
        end else if (fov_sum < $signed({2'b00, FOV_MIN})) begin
          fov_r <= FOV_MIN;
        end else begin
          fov_r <= fov_sum[FOV_W-1:0];
        end
      end
      if (state_r == S_PITCH) begin
        if (pitch_sum > 30'(PITCH_LIM)) begin
          pitch_r <= PITCH_LIM;
        end else if (pitch_sum < -30'(PITCH_LIM)) begin
          pitch_r <= -PITCH_LIM;
        end else begin
          pitch_r <= pitch_sum[PITCH_W-1:0];
        end
      end
      if (state_r == S_YAW_GO) begin
        yaw_r <= wrap_r[YAW_W-1:0];
      end
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dx_r <= in_tdata[11:0];
      dy_r <= in_tdata[23:12];
    end
    if (state_r == S_MUL_Y) begin
      wrap_r <= yaw_pos[WRAP_W-1:0];
    end else if (state_r == S_WRAP && wrap_r >= wrap_step) begin
      wrap_r <= wrap_r - wrap_step;
    end
    if (state_r == S_YAW_RUN && trig_stat.done) begin
      sy_r <= trig_sin;
      cy_r <= trig_cos;
    end
    if (state_r == S_PITCH_RUN && trig_stat.done) begin
      sp_r <= trig_sin;
      cp_r <= trig_cos;
    end
    if (state_r == S_PROD) begin
      case (step_r)
        3'd1:    front_x_r <= prod_rnd;
        3'd2:    front_z_r <= prod_rnd;
        3'd3:    up_x_r    <= prod_rnd;
        3'd4:    up_z_r    <= prod_rnd;
        default: ;
      endcase
    end
    if (out_load) begin
      out_tdata_r <= {fov_r, pitch_r, yaw_r,
                      up_z_r, rnd_unit(cp_r, 1'b0), up_x_r,
                      rnd_unit(cy_r, 1'b0), rnd_unit(sy_r, 1'b1),
                      front_z_r, rnd_unit(sp_r, 1'b0), front_x_r};
    end
  end

  // Output register: a loaded result stays until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  // Yaw is always fully reduced.
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    {7'd0, yaw_r} < YAW_MOD)
    else $error("yaw outside one turn");

  // Pitch and view angle stay within their clamps.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_r <= PITCH_LIM && pitch_r >= -PITCH_LIM)
    else $error("pitch outside clamp");

  a_fov_range: assert property (@(posedge clk) disable iff (!rst_n)
    fov_r >= FOV_MIN && fov_r <= FOV_MAX)
    else $error("view angle outside clamp");

  // The trig unit only finishes while the sequencer waits for it.
  a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
    trig_stat.done |-> (state_r == S_YAW_RUN || state_r == S_PITCH_RUN))
    else $error("trig result arrived outside a wait state");
`endif

endmodule

`default_nettype wire

>>> tb/tb_yaw_pitch_camera_basis.sv
// Self-checking testbench for the yaw/pitch camera basis block: pointer and scroll transfers in,
// one vector set per transfer out, compared against an in-bench fixed-point camera model.
// Depends on ypcb_pkg and yaw_pitch_camera_basis from src.
`timescale 1ns / 1ps

module tb_yaw_pitch_camera_basis;

  // The block is built with its default number of rotation steps, and the model follows it.
  localparam int CORDIC_STEPS = ypcb_pkg::TRIG_STEPS_DEF;
  // The tail wait grows with the number of rotation steps, as the block's response does.
  localparam int TAIL_CYCLES  = 2 * CORDIC_STEPS + 40;
  localparam int N_FIELDS     = 11;

  // Angle limits and constants, widened to 64-bit signed so the model never mixes signedness.
  localparam longint YAW_WRAP   = longint'(ypcb_pkg::YAW_MOD);
  localparam longint PITCH_MAX  = longint'(ypcb_pkg::PITCH_LIM);
  localparam longint VIEW_MIN   = longint'(ypcb_pkg::FOV_MIN);
  localparam longint VIEW_MAX   = longint'(ypcb_pkg::FOV_MAX);
  localparam longint UNIT_Q14   = 16384;
  localparam longint DEG180_Q16 = 180 * 65536;
  localparam longint CORDIC_X0  = 652032874;

  // One result transfer, laid out exactly as out_tdata: the last field sits in the lowest bits.
  typedef struct packed {
    logic        [ypcb_pkg::FOV_W-1:0]   view_angle;
    logic signed [ypcb_pkg::PITCH_W-1:0] pitch_now;
    logic        [ypcb_pkg::YAW_W-1:0]   yaw_now;
    logic signed [15:0]                  up_z;
    logic signed [15:0]                  up_y;
    logic signed [15:0]                  up_x;
    logic signed [15:0]                  right_z;
    logic signed [15:0]                  right_x;
    logic signed [15:0]                  front_z;
    logic signed [15:0]                  front_y;
    logic signed [15:0]                  front_x;
  } camera_basis_t;

  string basis_field_name [N_FIELDS] = '{"front_x", "front_y", "front_z", "right_x", "right_z",
                                         "up_x", "up_y", "up_z", "yaw_now", "pitch_now",
                                         "view_angle"};

  // Arctangent of 2^-i in degrees, Q.16, one entry per rotation step.
  longint atan_step_q16 [0:23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                   29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                                   14, 7, 4, 2, 1, 0};

  // ---------------------------------------------------------------------------------------------
  // Clock, reset and the ports of the block. Every input holds a known value from time zero.
  // ---------------------------------------------------------------------------------------------
  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_wen    = 1'b0;
  logic [15:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // delta_x[11:0], delta_y[23:12], scroll_step[31:24]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;         // front_x, front_y, front_z, right_x, right_z, up_x, up_y,
                                   // up_z, yaw_now, pitch_now, view_angle (lowest bit first)

  always #1 clk = ~clk;

  yaw_pitch_camera_basis #(
    .TRIG_STEPS (CORDIC_STEPS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------------------------
  // Camera model state. It mirrors the block's registers and is advanced once per accepted
  // input transfer, so the queue below always holds the vector sets still owed by the block.
  // ---------------------------------------------------------------------------------------------
  longint        speed_q12;
  longint        yaw_q12;
  longint        pitch_q12;
  longint        fov_q8;
  camera_basis_t basis_due [$];

  int errors        = 0;
  int report_budget = 100;
  int updates_sent  = 0;
  int results_seen  = 0;
  int speed_writes  = 0;
  int pitch_clamps  = 0;
  int yaw_wraps     = 0;
  int view_limits   = 0;
  bit calm          = 1'b0;   // set for the closing stretch: no idling on either side

  // Rotation-mode CORDIC on Q2.30 values. Angles arrive in degrees, Q.16, anywhere within
  // one turn either way; they are folded into -90..90 first, negating both results if folded.
  function automatic void cordic_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, t;
    bit     flip;
    int     i;
    x    = CORDIC_X0;
    y    = 0;
    flip = 1'b0;
    while (ang >= DEG180_Q16) ang -= 2 * DEG180_Q16;
    while (ang < -DEG180_Q16) ang += 2 * DEG180_Q16;
    if (ang > DEG180_Q16 / 2) begin
      ang -= DEG180_Q16;
      flip = 1'b1;
    end else if (ang < -DEG180_Q16 / 2) begin
      ang += DEG180_Q16;
      flip = 1'b1;
    end
    z = ang;
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      // The arithmetic shifts round toward minus infinity, as the block's do.
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step_q16[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step_q16[i];
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Symmetric rounding (half away from zero) followed by saturation to the unit range.
  function automatic longint unit_round(input longint v, input int sh);
    longint half, r;
    half = longint'(1) <<< (sh - 1);
    r    = (v >= 0) ? ((v + half) >>> sh) : -((-v + half) >>> sh);
    if (r > UNIT_Q14)  r = UNIT_Q14;
    if (r < -UNIT_Q14) r = -UNIT_Q14;
    return r;
  endfunction

  // Moves the camera by one pointer and scroll transfer and returns the vector set it owes.
  function automatic camera_basis_t advance_camera(input logic signed [11:0] dx,
                                                   input logic signed [11:0] dy,
                                                   input logic signed [7:0]  sc);
    camera_basis_t b;
    longint        v, sy, cy, sp, cp;
    v = yaw_q12 + longint'(dx) * speed_q12;
    if (v < 0 || v >= YAW_WRAP) yaw_wraps++;
    v = v % YAW_WRAP;
    if (v < 0) v += YAW_WRAP;
    yaw_q12 = v;

    v = pitch_q12 + longint'(dy) * speed_q12;
    if (v > PITCH_MAX || v < -PITCH_MAX) pitch_clamps++;
    if (v > PITCH_MAX)  v = PITCH_MAX;
    if (v < -PITCH_MAX) v = -PITCH_MAX;
    pitch_q12 = v;

    v = fov_q8 - longint'(sc) * 256;
    if (v >= VIEW_MAX || v <= VIEW_MIN) view_limits++;
    if (v > VIEW_MAX) v = VIEW_MAX;
    if (v < VIEW_MIN) v = VIEW_MIN;
    fov_q8 = v;

    cordic_sincos(yaw_q12 * 16, sy, cy);
    cordic_sincos(pitch_q12 * 16, sp, cp);
    b.front_x    = 16'(unit_round(cp * cy, 46));
    b.front_y    = 16'(unit_round(sp, 16));
    b.front_z    = 16'(unit_round(cp * sy, 46));
    b.right_x    = 16'(unit_round(-sy, 16));
    b.right_z    = 16'(unit_round(cy, 16));
    b.up_x       = 16'(unit_round(-(cy * sp), 46));
    b.up_y       = 16'(unit_round(cp, 16));
    b.up_z       = 16'(unit_round(-(sy * sp), 46));
    b.yaw_now    = yaw_q12[ypcb_pkg::YAW_W-1:0];
    b.pitch_now  = pitch_q12[ypcb_pkg::PITCH_W-1:0];
    b.view_angle = fov_q8[ypcb_pkg::FOV_W-1:0];
    return b;
  endfunction

  function automatic longint basis_field(input camera_basis_t b, input int k);
    case (k)
      0:       return longint'(b.front_x);
      1:       return longint'(b.front_y);
      2:       return longint'(b.front_z);
      3:       return longint'(b.right_x);
      4:       return longint'(b.right_z);
      5:       return longint'(b.up_x);
      6:       return longint'(b.up_y);
      7:       return longint'(b.up_z);
      8:       return longint'(b.yaw_now);
      9:       return longint'(b.pitch_now);
      default: return longint'(b.view_angle);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Result side. The receiver drops tready in bursts of random length with ready stretches
  // of varied length between them, some of them long. Every result transfer is compared,
  // field by field, with the oldest vector set still owed.
  // ---------------------------------------------------------------------------------------------
  int unsigned ready_run = 0;

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
      ready_run  <= 0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (out_tready && $urandom_range(0, 1) == 0) begin
      out_tready <= 1'b0;
      ready_run  <= $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b1;
      ready_run  <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin
    camera_basis_t got, want;
    int            k;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if ($isunknown(out_tdata)) begin
        errors++;
        if (report_budget > 0) begin
          report_budget--;
          $display("%0t: result transfer carries unknown bits: %h", $time, out_tdata);
        end
      end
      if (basis_due.size() == 0) begin
        errors++;
        if (report_budget > 0) begin
          report_budget--;
          $display("%0t: result transfer with nothing owed: expected none, got %h",
                   $time, out_tdata);
        end
      end else begin
        want = basis_due.pop_front();
        for (k = 0; k < N_FIELDS; k++) begin
          if (basis_field(got, k) != basis_field(want, k)) begin
            errors++;
            if (report_budget > 0) begin
              report_budget--;
              $display("%0t: %s mismatch: expected %0d, got %0d", $time, basis_field_name[k],
                       basis_field(want, k), basis_field(got, k));
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Input side. One pointer and scroll transfer at a time; tvalid stays high from one item to
  // the next and is only lowered for a gap or a pause, so it never sees two assignments in one
  // time step. The model is advanced at the edge on which the transfer completes.
  // ---------------------------------------------------------------------------------------------
  task automatic push_motion(input logic signed [11:0] dx, input logic signed [11:0] dy,
                             input logic signed [7:0] sc);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sc, dy, dx};
    do @(posedge clk); while (!in_tready);
    basis_due.push_back(advance_camera(dx, dy, sc));
    updates_sent++;
  endtask

  // Holds the sender until every vector set owed has arrived, then lets the block settle.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (basis_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The turn speed register is only written while the block has nothing in flight.
  task automatic set_turn_speed(input logic [15:0] speed);
    quiesce();
    cfg_wen   <= 1'b1;
    cfg_wdata <= speed;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    speed_q12 = longint'(speed);
    speed_writes++;
  endtask

  // Random motion. Half the items are small steps so pitch wanders freely inside its clamp
  // and all four quadrants of yaw are visited; the rest are medium or full-range steps
  // that drive the clamps and the yaw wrap, with full-range scroll to hit the view limits.
  task automatic send_random_motion(input int count);
    logic signed [11:0] dx, dy;
    logic signed [7:0]  sc;
    int                 n;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          dx = 12'($urandom);
          dy = 12'($urandom);
          sc = 8'($urandom);
        end
        1: begin
          dx = 12'(int'($urandom_range(0, 1024)) - 512);
          dy = 12'(int'($urandom_range(0, 1024)) - 512);
          sc = 8'($urandom);
        end
        default: begin
          dx = 12'(int'($urandom_range(0, 64)) - 32);
          dy = 12'(int'($urandom_range(0, 64)) - 32);
          sc = 8'(int'($urandom_range(0, 6)) - 3);
        end
      endcase
      push_motion(dx, dy, sc);
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Nothing written yet: all three angles must start from their reset values,
  // and the view angle must saturate at both of its limits.
  task automatic test_reset_defaults();
    push_motion(0, 0, 0);
    push_motion(0, 0, 127);
    push_motion(0, 0, -128);
    push_motion(0, 0, 44);
  endtask

  // One degree per count keeps both angles on whole degrees, so yaw lands exactly on the
  // quadrant boundaries, wraps in both directions, and pitch meets its clamp exactly and beyond.
  task automatic test_angle_quadrants();
    set_turn_speed(16'd4096);
    push_motion(-90, 0, 0);
    push_motion(-90, 0, 0);
    push_motion(-90, 0, 0);
    push_motion(-1, 0, 0);
    push_motion(1, 0, 0);
    push_motion(45, 45, 0);
    push_motion(0, 44, 0);
    push_motion(0, 1, 0);
    push_motion(0, -178, 0);
    push_motion(135, -1, 0);
    push_motion(0, 89, 0);
  endtask

  // Largest pointer steps at the largest turn speed, then a zero turn speed that must leave
  // both angles untouched however far the pointer moves.
  task automatic test_extreme_steps();
    set_turn_speed(16'hFFFF);
    push_motion(2047, 2047, 1);
    push_motion(-2048, -2048, -1);
    push_motion(-2048, 2047, 0);
    push_motion(2047, -2048, 0);
    set_turn_speed(16'd0);
    push_motion(-2048, 2047, 127);
    push_motion(2047, -2048, -128);
  endtask

  // Random motion at a random turn speed, with one full pause of the sender half way through.
  task automatic test_random_paused();
    set_turn_speed(16'($urandom));
    send_random_motion(250);
    quiesce();
    send_random_motion(250);
  endtask

  // Random motion across a spread of turn speeds, the extremes among them.
  task automatic test_random_speeds();
    set_turn_speed(16'($urandom_range(1, 8192)));
    send_random_motion(500);
    set_turn_speed(16'hFFFF);
    send_random_motion(250);
    set_turn_speed(16'd1);
    send_random_motion(150);
    set_turn_speed(16'd0);
    send_random_motion(100);
  endtask

  // Closing stretch at the reset turn speed with both sides running flat out.
  task automatic test_quiet_tail();
    set_turn_speed(ypcb_pkg::TS_RST);
    calm = 1'b1;
    send_random_motion(400);
  endtask

  initial begin
    speed_q12 = longint'(ypcb_pkg::TS_RST);
    yaw_q12   = longint'(ypcb_pkg::YAW_RST);
    pitch_q12 = 0;
    fov_q8    = longint'(ypcb_pkg::FOV_RST);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_angle_quadrants();
    test_extreme_steps();
    test_random_paused();
    test_random_speeds();
    test_quiet_tail();

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d camera updates (%0d results checked) over %0d turn speed writes.",
             updates_sent, results_seen, speed_writes);
    $display("Pitch clamped %0d times, yaw wrapped %0d times, view angle at a limit %0d times.",
             pitch_clamps, yaw_wraps, view_limits);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a fifth of this.
  initial begin
    #2000000;
    $display("Timed out with %0d vector sets still owed.", basis_due.size());
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
src/ypcb_pkg.sv
src/ypcb_mul.sv
src/ypcb_cordic.sv
src/yaw_pitch_camera_basis.sv
tb/tb_yaw_pitch_camera_basis.sv
